// ----- rtl/glbp_pkg.sv -----
// Package for the greedy line box placer.
// Holds payload structs, controller/datapath command and status structs and codes.
// No dependencies.
`default_nettype none

package glbp_pkg;

    localparam int LINE_ITEMS_DEF = 32;

    localparam int DIM_W   = 20;
    localparam int TAG_W   = 16;
    localparam int VA_W    = 3;
    localparam int ALIGN_W = 2;
    localparam int POSX_W  = 22;
    localparam int POSY_W  = 24;
    localparam int TOP_W   = 23;
    localparam int CFG_IDX_W = 2;

    localparam int POSX_MAX = 4194303;
    localparam int POSY_MAX = 8388607;
    localparam int POSY_MIN = -8388608;

    localparam logic [DIM_W-1:0] CW_RESET = 20'd12800;

    // Reciprocal of five, exact for floor division of values below 2**22.
    localparam logic [DIM_W-1:0] RECIP5 = 20'd838861;
    localparam int RECIP_SHIFT = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTAINER_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ALIGN      = 2'd1;

    localparam logic [ALIGN_W-1:0] ALIGN_LEFT   = 2'd0;
    localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 2'd1;
    localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 2'd2;

    localparam logic [VA_W-1:0] VA_TOP    = 3'd0;
    localparam logic [VA_W-1:0] VA_MIDDLE = 3'd1;
    localparam logic [VA_W-1:0] VA_BOTTOM = 3'd2;
    localparam logic [VA_W-1:0] VA_SUB    = 3'd3;
    localparam logic [VA_W-1:0] VA_SUPER  = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0] item_tag;
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
        logic [DIM_W-1:0] left_inset;
        logic             hard_break;
        logic             is_text;
        logic [VA_W-1:0]  valign;
        logic             last_item;
    } item_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]         out_tag;
        logic [POSX_W-1:0]        pos_x;
        logic signed [POSY_W-1:0] pos_y;
        logic                     end_of_line;
        logic                     block_done;
        logic [TOP_W-1:0]         block_height;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] box_height;
        logic [DIM_W-1:0] box_width;
    } geo_t;

    typedef struct packed {
        logic [VA_W-1:0]  valign;
        logic             is_text;
        logic [DIM_W-1:0] left_inset;
        logic [TAG_W-1:0] item_tag;
    } attr_t;

    typedef struct packed {
        logic latch_item;
        logic buffer_item;
        logic prep_close;
        logic emit_entry;
        logic final_close;
    } cmd_t;

    typedef struct packed {
        logic need_preclose;
        logic item_close;
        logic out_free;
        logic last_entry;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/greedy_line_box_placer.sv -----
// Top level of the greedy line box placer.
// Joins glbp_ctrl and glbp_datapath; uses glbp_pkg.
//
//   Channel   Signals                          Direction
//   input     in_valid, in_ready, in_item      item in
//   output    out_valid, out_ready, out_result result out
//   config    cfg_we, cfg_index, cfg_data      register write
//
// An item passes through an accept state and a buffer write state; each line that it
// closes adds a setup state and an emit state that reads the line buffer RAM one
// entry per cycle while the output is free.
// Reset clears the line state and loads the configuration reset values.
// A stalled output holds the emit loop; a new item is taken while the last result waits.
`default_nettype none

module greedy_line_box_placer
    import glbp_pkg::*;
#(
    parameter int LINE_ITEMS = LINE_ITEMS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire item_in_t             in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t st;
    logic    item_last;

    glbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_last (item_last),
        .in_ready  (in_ready),
        .st        (st),
        .cmd       (cmd)
    );

    glbp_datapath #(
        .LINE_ITEMS (LINE_ITEMS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (in_item),
        .cmd        (cmd),
        .st         (st),
        .item_last  (item_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block still ready in the cycle after an accepted transfer");

    a_done_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.block_done |-> out_result.end_of_line)
        else $error("block_done on a result that does not end a line");

    a_height_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_result.block_done |-> out_result.block_height == '0)
        else $error("block_height nonzero without block_done");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit_entry))
        else $error("result appeared without an emit command");

endmodule

`default_nettype wire

// ----- rtl/glbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the line buffer; no dependencies.
`default_nettype none

module glbp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/glbp_ctrl.sv -----
// Controller state machine of the greedy line box placer.
// Sequences accept, buffer write, line setup and emission; uses glbp_pkg.
`default_nettype none

module glbp_ctrl
    import glbp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    item_last,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUF  = 2'd1;
    localparam logic [1:0] S_PREP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       post_reg, post_next;

    always_comb
    begin
        state_next = state_reg;
        post_next  = post_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    if (st.need_preclose)
                    begin
                        post_next  = 1'b0;
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_BUF;
                    end
                end
            end
            S_BUF:
            begin
                cmd.buffer_item = 1'b1;
                if (st.item_close)
                begin
                    post_next  = 1'b1;
                    state_next = S_PREP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREP:
            begin
                cmd.prep_close = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.final_close = post_reg & item_last;
                if (st.out_free)
                begin
                    cmd.emit_entry = 1'b1;
                    if (st.last_entry)
                    begin
                        state_next = post_reg ? S_IDLE : S_BUF;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/glbp_datapath.sv -----
// Datapath of the greedy line box placer: line state, line buffer RAMs,
// alignment and vertical placement arithmetic, output register.
// Uses glbp_pkg and glbp_ram.
`default_nettype none

module glbp_datapath
    import glbp_pkg::*;
#(
    parameter int LINE_ITEMS = LINE_ITEMS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire item_in_t             in_item,
    input  wire cmd_t                 cmd,
    output status_t                   st,
    output logic                      item_last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output result_t                   out_result
);

    localparam int IDX_W = $clog2(LINE_ITEMS);
    localparam int CNT_W = $clog2(LINE_ITEMS + 1);
    localparam int SUM_W = DIM_W + CNT_W;
    localparam int X_W   = SUM_W + 1;
    localparam int PX_W  = X_W + 1;
    localparam int PY_W  = POSY_W + 2;
    localparam int GEO_W = $bits(geo_t);
    localparam int ATT_W = $bits(attr_t);

    localparam logic [CNT_W-1:0]       CNT_FULL = CNT_W'(LINE_ITEMS);
    localparam logic [PX_W-1:0]        PX_HI    = PX_W'(POSX_MAX);
    localparam logic signed [PY_W-1:0] PY_HI    = PY_W'(POSY_MAX);
    localparam logic signed [PY_W-1:0] PY_LO    = PY_W'(POSY_MIN);

    item_in_t          item_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIM_W-1:0]  hmax_reg, hmax_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [DIM_W-1:0]  cw_reg, cw_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [DIM_W-1:0]  sub_reg, sub_next;
    logic [DIM_W-1:0]  sup_reg, sup_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    geo_t              geo_wr, geo_rd;
    attr_t             attr_wr, attr_rd;
    logic [GEO_W-1:0]  geo_rdata;
    logic [ATT_W-1:0]  attr_rdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic              count_full;
    logic [SUM_W:0]    sum_plus_w;
    logic [SUM_W-1:0]  cw_ext;
    logic [SUM_W-1:0]  gap;
    logic [2*DIM_W-1:0] sub_prod;
    logic [DIM_W+1:0]  hmax3;
    logic [2*DIM_W:0]  sup_prod;
    logic [DIM_W-1:0]  hdiff;
    logic signed [PY_W-1:0] py_off;
    logic signed [PY_W-1:0] py_sum;
    logic [PX_W-1:0]   px_sum;
    logic [TOP_W:0]    top_sum;
    logic [TOP_W-1:0]  top_sat;
    logic              last_entry;
    logic              blk_end;

    assign geo_wr.box_width   = item_reg.box_width;
    assign geo_wr.box_height  = item_reg.box_height;
    assign attr_wr.item_tag   = item_reg.item_tag;
    assign attr_wr.left_inset = item_reg.left_inset;
    assign attr_wr.is_text    = item_reg.is_text;
    assign attr_wr.valign     = item_reg.valign;

    assign rd_en   = cmd.prep_close | (cmd.emit_entry & ~last_entry);
    assign rd_addr = cmd.prep_close ? '0 : IDX_W'(idx_reg + 1'b1);

    glbp_ram #(
        .WIDTH (GEO_W),
        .DEPTH (LINE_ITEMS)
    ) u_geo_ram (
        .clk   (clk),
        .we    (cmd.buffer_item),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (geo_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (geo_rdata)
    );

    glbp_ram #(
        .WIDTH (ATT_W),
        .DEPTH (LINE_ITEMS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (cmd.buffer_item),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (attr_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (attr_rdata)
    );

    assign geo_rd  = geo_t'(geo_rdata);
    assign attr_rd = attr_t'(attr_rdata);

    assign count_full = (count_reg >= CNT_FULL);
    assign sum_plus_w = {1'b0, sum_reg} + (SUM_W + 1)'(in_item.box_width);
    assign cw_ext     = SUM_W'(cw_reg);
    assign gap        = cw_ext - sum_reg;
    assign last_entry = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign blk_end    = cmd.final_close & last_entry;

    assign st.need_preclose = in_item.hard_break ? count_full :
        (((sum_reg != '0) && (sum_plus_w > (SUM_W + 1)'(cw_reg))) || count_full);
    assign st.item_close = item_reg.hard_break | item_reg.last_item;
    assign st.out_free   = ~out_valid_reg | out_ready;
    assign st.last_entry = last_entry;
    assign item_last     = item_reg.last_item;

    assign sub_prod = (2*DIM_W)'(hmax_reg) * (2*DIM_W)'(RECIP5);
    assign hmax3    = (DIM_W + 2)'(hmax_reg) + (DIM_W + 2)'({hmax_reg, 1'b0});
    assign sup_prod = (2*DIM_W + 1)'(hmax3[DIM_W+1:1]) * (2*DIM_W + 1)'(RECIP5);

    assign hdiff = hmax_reg - geo_rd.box_height;

    always_comb
    begin
        py_off = '0;
        if (!attr_rd.is_text)
        begin
            unique case (attr_rd.valign)
                VA_MIDDLE: py_off = $signed(PY_W'(hdiff >> 1));
                VA_BOTTOM: py_off = $signed(PY_W'(hdiff));
                VA_SUB:    py_off = $signed(PY_W'(sub_reg));
                VA_SUPER:  py_off = -$signed(PY_W'(sup_reg));
                default:   py_off = '0;
            endcase
        end
    end

    assign py_sum  = $signed(PY_W'(top_reg)) + py_off;
    assign px_sum  = PX_W'(x_reg) + PX_W'(attr_rd.left_inset);
    assign top_sum = (TOP_W + 1)'(top_reg) + (TOP_W + 1)'(hmax_reg);
    assign top_sat = top_sum[TOP_W] ? {TOP_W{1'b1}} : top_sum[TOP_W-1:0];

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        hmax_next      = hmax_reg;
        top_next       = top_reg;
        cw_next        = cw_reg;
        align_next     = align_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        sub_next       = sub_reg;
        sup_next       = sup_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_next       = out_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_CONTAINER_WIDTH)
            begin
                cw_next = cfg_data;
            end
            else if (cfg_index == CFG_TEXT_ALIGN)
            begin
                align_next = cfg_data[ALIGN_W-1:0];
            end
        end

        if (cmd.buffer_item)
        begin
            count_next = count_reg + 1'b1;
            sum_next   = sum_reg + SUM_W'(item_reg.box_width);
            if (item_reg.box_height > hmax_reg)
            begin
                hmax_next = item_reg.box_height;
            end
        end

        if (cmd.prep_close)
        begin
            idx_next = '0;
            sub_next = DIM_W'(sub_prod >> RECIP_SHIFT);
            sup_next = DIM_W'(sup_prod >> RECIP_SHIFT);
            x_next   = '0;
            if (cw_ext > sum_reg)
            begin
                if (align_reg == ALIGN_CENTER)
                begin
                    x_next = X_W'(gap >> 1);
                end
                else if (align_reg == ALIGN_RIGHT)
                begin
                    x_next = X_W'(gap);
                end
            end
        end

        if (cmd.emit_entry)
        begin
            out_valid_next       = 1'b1;
            out_next.out_tag     = attr_rd.item_tag;
            out_next.pos_x       = (px_sum > PX_HI) ? POSX_W'(POSX_MAX)
                                                    : px_sum[POSX_W-1:0];
            out_next.pos_y       = (py_sum > PY_HI) ? POSY_W'(POSY_MAX) :
                                   (py_sum < PY_LO) ? POSY_W'(POSY_MIN) :
                                   py_sum[POSY_W-1:0];
            out_next.end_of_line = last_entry;
            out_next.block_done  = blk_end;
            out_next.block_height = blk_end ? top_sat : '0;
            idx_next = IDX_W'(idx_reg + 1'b1);
            x_next   = x_reg + X_W'(geo_rd.box_width);
            if (last_entry)
            begin
                count_next = '0;
                sum_next   = '0;
                hmax_next  = '0;
                top_next   = cmd.final_close ? '0 : top_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            hmax_reg      <= '0;
            top_reg       <= '0;
            cw_reg        <= CW_RESET;
            align_reg     <= ALIGN_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            hmax_reg      <= hmax_next;
            top_reg       <= top_next;
            cw_reg        <= cw_next;
            align_reg     <= align_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_item;
        end
        idx_reg <= idx_next;
        x_reg   <= x_next;
        sub_reg <= sub_next;
        sup_reg <= sup_next;
        out_reg <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire
